>>> rtl/segment_deque_with_duration_sum_defines.svh
// assertion macros used by the checker file sdq_checker.sv
// no dependencies
`ifndef SEGMENT_DEQUE_WITH_DURATION_SUM_DEFINES_SVH
`define SEGMENT_DEQUE_WITH_DURATION_SUM_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define SDQ_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked only out of reset
`define SDQ_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sdq_pkg.sv
// types and constants for the segment deque
// no dependencies
package sdq_pkg;

  localparam int OP_W     = 3;
  localparam int PAY_W    = 64;
  localparam int DUR_W    = 32;
  localparam int SUM_W    = 40;
  localparam int CNT_W    = 6;

  localparam logic [OP_W-1:0] OP_PUSH       = 3'd0;
  localparam logic [OP_W-1:0] OP_FETCH      = 3'd1;
  localparam logic [OP_W-1:0] OP_DROP_BACK  = 3'd2;
  localparam logic [OP_W-1:0] OP_DROP_FRONT = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic latch;   // capture the input beat
    logic rd;      // read head and back slots
    logic apply;   // perform the operation
    logic load;    // load the result registers
  } sdq_cmd_t;

endpackage

>>> rtl/sdq_ctrl.sv
// sequencer for the segment deque: accept, read, apply, read, load
// depends on sdq_pkg
module sdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output sdq_pkg::sdq_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RD_PRE  = 3'd1;
  localparam logic [2:0] ST_APPLY   = 3'd2;
  localparam logic [2:0] ST_RD_POST = 3'd3;
  localparam logic [2:0] ST_LOAD    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = ST_RD_PRE;
        end
      end
      ST_RD_PRE: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_RD_POST;
      end
      ST_RD_POST: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> rtl/sdq_datapath.sv
// slot memory, head/tail pointers, running duration sum and result registers
// depends on sdq_pkg
module sdq_datapath #(
  parameter int DEPTH         = 64,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sdq_pkg::sdq_cmd_t              cmd,
  input  logic [sdq_pkg::OP_W-1:0]       in_operation,
  input  logic [sdq_pkg::PAY_W-1:0]      in_segment_payload,
  input  logic [sdq_pkg::DUR_W-1:0]      in_segment_duration,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [sdq_pkg::PAY_W-1:0]      out_payload,
  output logic [sdq_pkg::DUR_W-1:0]      out_duration,
  output logic                           out_is_empty,
  output logic                           out_is_full,
  output logic [sdq_pkg::CNT_W-1:0]      out_item_count,
  output logic [sdq_pkg::SUM_W-1:0]      out_total_duration,
  output logic [sdq_pkg::PAY_W-1:0]      out_front_payload,
  output logic [sdq_pkg::DUR_W-1:0]      out_front_duration,
  output logic [sdq_pkg::PAY_W-1:0]      out_back_payload,
  output logic [sdq_pkg::DUR_W-1:0]      out_back_duration
);

  localparam int PW     = $clog2(DEPTH);
  localparam int EW     = PAYLOAD_WIDTH + sdq_pkg::DUR_W;
  localparam int CEXT_W = PW + 1 + sdq_pkg::CNT_W;
  localparam int PEXT_W = PAYLOAD_WIDTH + sdq_pkg::PAY_W;
  localparam logic [PW-1:0] LAST   = PW'(DEPTH - 1);
  localparam logic [PW:0]   DEPTHC = (PW + 1)'(DEPTH);

  // slot layout: duration above payload
  logic [EW-1:0] mem [DEPTH];

  logic [sdq_pkg::OP_W-1:0]  op_r;
  logic [PAYLOAD_WIDTH-1:0]  pay_r;
  logic [sdq_pkg::DUR_W-1:0] dur_r;

  logic [PW-1:0]              head_r, head_nxt;
  logic [PW-1:0]              tail_r, tail_nxt;
  logic [sdq_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic                       ok_r, ok_nxt;
  logic [PAYLOAD_WIDTH-1:0]   got_pay_r, got_pay_nxt;
  logic [sdq_pkg::DUR_W-1:0]  got_dur_r, got_dur_nxt;
  logic [EW-1:0]              rda_r, rdb_r;
  logic                       wr_en;
  logic                       out_valid_r;

  logic [PW-1:0] head_inc, tail_inc, tail_dec;
  logic          empty, full;
  logic [PW:0]   cnt;
  logic [CEXT_W-1:0] cnt_ext;
  logic [PEXT_W-1:0] got_ext, front_ext, back_ext;

  assign head_inc = (head_r == LAST) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST) ? '0 : tail_r + 1'b1;
  assign tail_dec = (tail_r == '0) ? LAST : tail_r - 1'b1;
  assign empty    = (head_r == tail_r);
  assign full     = (tail_inc == head_r);

  always_comb begin
    if (tail_r >= head_r) begin
      cnt = {1'b0, tail_r} - {1'b0, head_r};
    end else begin
      cnt = {1'b0, tail_r} + DEPTHC - {1'b0, head_r};
    end
  end
  assign cnt_ext = CEXT_W'(cnt);

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    sum_nxt     = sum_r;
    ok_nxt      = 1'b0;
    got_pay_nxt = '0;
    got_dur_nxt = '0;
    wr_en       = 1'b0;
    case (op_r)
      sdq_pkg::OP_PUSH: begin
        if (!full) begin
          wr_en    = 1'b1;
          tail_nxt = tail_inc;
          sum_nxt  = sum_r + sdq_pkg::SUM_W'(dur_r);
          ok_nxt   = 1'b1;
        end
      end
      sdq_pkg::OP_FETCH: begin
        if (!empty) begin
          got_pay_nxt = rda_r[PAYLOAD_WIDTH-1:0];
          got_dur_nxt = rda_r[EW-1:PAYLOAD_WIDTH];
          sum_nxt     = sum_r - sdq_pkg::SUM_W'(rda_r[EW-1:PAYLOAD_WIDTH]);
          head_nxt    = head_inc;
          ok_nxt      = 1'b1;
        end
      end
      sdq_pkg::OP_DROP_BACK: begin
        if (!empty) begin
          tail_nxt = tail_dec;
          sum_nxt  = sum_r - sdq_pkg::SUM_W'(rdb_r[EW-1:PAYLOAD_WIDTH]);
          ok_nxt   = 1'b1;
        end
      end
      sdq_pkg::OP_DROP_FRONT: begin
        if (!empty) begin
          head_nxt = head_inc;
          sum_nxt  = sum_r - sdq_pkg::SUM_W'(rda_r[EW-1:PAYLOAD_WIDTH]);
          ok_nxt   = 1'b1;
        end
      end
      sdq_pkg::OP_CLEAR: begin
        head_nxt = '0;
        tail_nxt = '0;
        sum_nxt  = '0;
        ok_nxt   = 1'b1;
      end
      default: ok_nxt = 1'b0;
    endcase
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_operation;
      pay_r <= in_segment_payload[PAYLOAD_WIDTH-1:0];
      dur_r <= in_segment_duration;
    end
  end

  // slot memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.apply && wr_en) begin
      mem[tail_r] <= {dur_r, pay_r};
    end
    if (cmd.rd) begin
      rda_r <= mem[head_r];
      rdb_r <= mem[tail_dec];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      sum_r  <= '0;
    end else if (cmd.apply) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      ok_r      <= ok_nxt;
      got_pay_r <= got_pay_nxt;
      got_dur_r <= got_dur_nxt;
    end
  end

  assign got_ext   = PEXT_W'(got_pay_r);
  assign front_ext = PEXT_W'(rda_r[PAYLOAD_WIDTH-1:0]);
  assign back_ext  = PEXT_W'(rdb_r[PAYLOAD_WIDTH-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.load;
    end
  end

  // front and back read as zero on an empty queue
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_accepted       <= ok_r;
      out_payload        <= got_ext[sdq_pkg::PAY_W-1:0];
      out_duration       <= got_dur_r;
      out_is_empty       <= empty;
      out_is_full        <= full;
      out_item_count     <= cnt_ext[sdq_pkg::CNT_W-1:0];
      out_total_duration <= sum_r;
      out_front_payload  <= empty ? '0 : front_ext[sdq_pkg::PAY_W-1:0];
      out_front_duration <= empty ? '0 : rda_r[EW-1:PAYLOAD_WIDTH];
      out_back_payload   <= empty ? '0 : back_ext[sdq_pkg::PAY_W-1:0];
      out_back_duration  <= empty ? '0 : rdb_r[EW-1:PAYLOAD_WIDTH];
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/segment_deque_with_duration_sum.sv
// Segment deque with running duration sum.
// Command channel: an operation beat (in_operation, in_segment_payload,
// in_segment_duration) is taken at a clock edge where start is high and
// busy is low. Operations: push at tail, fetch from head, drop newest,
// drop oldest, clear. Up to DEPTH-1 segments are held.
// Result channel: out_valid is high for exactly one cycle with the result
// beat: success flag, fetched segment, empty/full flags, count, total
// duration, and the front and back segments after the operation.
// Sequencing: busy stays high while the block reads the slots, applies
// the operation, reads again and loads the result registers; out_valid
// is registered from the load step, and busy is low again when it rises.
// The steps are set by the slot memory: each operation reads the head and
// back slots once before and once after the update, with registered read data.
// The receiver cannot stall; a result is taken in the cycle it is shown.
// Reset (rst_n low, synchronous) empties the queue, zeroes the sum and
// returns the sequencer to idle; slot contents are left as they are.
// depends on sdq_pkg, sdq_ctrl, sdq_datapath
module segment_deque_with_duration_sum #(
  parameter int DEPTH         = 64,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [sdq_pkg::OP_W-1:0]       in_operation,
  input  logic [sdq_pkg::PAY_W-1:0]      in_segment_payload,
  input  logic [sdq_pkg::DUR_W-1:0]      in_segment_duration,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [sdq_pkg::PAY_W-1:0]      out_payload,
  output logic [sdq_pkg::DUR_W-1:0]      out_duration,
  output logic                           out_is_empty,
  output logic                           out_is_full,
  output logic [sdq_pkg::CNT_W-1:0]      out_item_count,
  output logic [sdq_pkg::SUM_W-1:0]      out_total_duration,
  output logic [sdq_pkg::PAY_W-1:0]      out_front_payload,
  output logic [sdq_pkg::DUR_W-1:0]      out_front_duration,
  output logic [sdq_pkg::PAY_W-1:0]      out_back_payload,
  output logic [sdq_pkg::DUR_W-1:0]      out_back_duration
);

  sdq_pkg::sdq_cmd_t cmd;

  sdq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  sdq_datapath #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_operation        (in_operation),
    .in_segment_payload  (in_segment_payload),
    .in_segment_duration (in_segment_duration),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_payload         (out_payload),
    .out_duration        (out_duration),
    .out_is_empty        (out_is_empty),
    .out_is_full         (out_is_full),
    .out_item_count      (out_item_count),
    .out_total_duration  (out_total_duration),
    .out_front_payload   (out_front_payload),
    .out_front_duration  (out_front_duration),
    .out_back_payload    (out_back_payload),
    .out_back_duration   (out_back_duration)
  );

endmodule

>>> rtl/sdq_checker.sv
// port-level checks for the segment deque, bound to the top level
// depends on sdq_pkg and segment_deque_with_duration_sum_defines.svh
`include "segment_deque_with_duration_sum_defines.svh"

module sdq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic                      out_is_empty,
  input logic                      out_is_full,
  input logic [sdq_pkg::CNT_W-1:0] out_item_count,
  input logic [sdq_pkg::PAY_W-1:0] out_front_payload,
  input logic [sdq_pkg::DUR_W-1:0] out_back_duration
);

  // an accepted beat keeps the block busy until its result is out
  `SDQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accept did not raise busy")

  // a result beat only shows once the sequencer is idle again
  `SDQ_ASSERT_NOW(a_result_idle, clk, rst_n, out_valid, !busy, "result shown while busy")

  `SDQ_ASSERT_NEXT(a_strobe_pulse, clk, rst_n, out_valid, !out_valid, "result strobe longer than one cycle")

  `SDQ_ASSERT_NOW(a_empty_not_full, clk, rst_n, out_valid, !(out_is_empty && out_is_full), "queue both empty and full")

  // empty queue reports no entries and zero front and back
  `SDQ_ASSERT_NOW(a_empty_zero, clk, rst_n, out_valid && out_is_empty, (out_item_count == '0) && (out_front_payload == '0) && (out_back_duration == '0), "empty queue with entries")

endmodule

bind segment_deque_with_duration_sum sdq_checker u_sdq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_is_empty      (out_is_empty),
  .out_is_full       (out_is_full),
  .out_item_count    (out_item_count),
  .out_front_payload (out_front_payload),
  .out_back_duration (out_back_duration)
);

>>> tb/sv/tb_top.sv
// testbench for segment_deque_with_duration_sum: directed and random deque traffic
// checked beat by beat against a behavioral ring-buffer predictor
// depends on sdq_pkg and the segment_deque_with_duration_sum rtl
module tb_top;
  import sdq_pkg::*;

  localparam int DEPTH         = 64;
  localparam int PAYLOAD_WIDTH = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_OPS    = 700;
  localparam int MAX_REPORTS   = 10;
  localparam logic [OP_W-1:0] OP_FIRST_RSVD = 3'd5;
  localparam logic [OP_W-1:0] OP_LAST_RSVD  = 3'd7;

  typedef struct packed {
    logic             accepted;
    logic [PAY_W-1:0] payload;
    logic [DUR_W-1:0] duration;
    logic             is_empty;
    logic             is_full;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] total;
    logic [PAY_W-1:0] front_payload;
    logic [DUR_W-1:0] front_duration;
    logic [PAY_W-1:0] back_payload;
    logic [DUR_W-1:0] back_duration;
  } deque_status_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [OP_W-1:0]  in_operation;
  logic [PAY_W-1:0] in_segment_payload;
  logic [DUR_W-1:0] in_segment_duration;
  logic             out_valid;
  logic             out_accepted;
  logic [PAY_W-1:0] out_payload;
  logic [DUR_W-1:0] out_duration;
  logic             out_is_empty;
  logic             out_is_full;
  logic [CNT_W-1:0] out_item_count;
  logic [SUM_W-1:0] out_total_duration;
  logic [PAY_W-1:0] out_front_payload;
  logic [DUR_W-1:0] out_front_duration;
  logic [PAY_W-1:0] out_back_payload;
  logic [DUR_W-1:0] out_back_duration;

  // predictor state
  logic [PAY_W-1:0] seg_pay_ring [DEPTH];
  logic [DUR_W-1:0] seg_dur_ring [DEPTH];
  int unsigned      ring_head;
  int unsigned      ring_tail;
  logic [SUM_W-1:0] ring_total;

  deque_status_t status_q [$];

  bit          no_gaps;
  int unsigned beats_sent;
  int unsigned ops_rejected;
  int unsigned results_checked;
  int unsigned peak_count;
  int unsigned full_hits;
  int unsigned mismatch_count;
  int unsigned unexpected_count;
  int unsigned stall_cycles;

  segment_deque_with_duration_sum #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_segment_payload  (in_segment_payload),
    .in_segment_duration (in_segment_duration),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_payload         (out_payload),
    .out_duration        (out_duration),
    .out_is_empty        (out_is_empty),
    .out_is_full         (out_is_full),
    .out_item_count      (out_item_count),
    .out_total_duration  (out_total_duration),
    .out_front_payload   (out_front_payload),
    .out_front_duration  (out_front_duration),
    .out_back_payload    (out_back_payload),
    .out_back_duration   (out_back_duration)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned ring_next(int unsigned i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int unsigned ring_prev(int unsigned i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  // applies one operation to the predictor ring and returns the status after it
  function automatic deque_status_t apply_deque_op(logic [OP_W-1:0] op, logic [PAY_W-1:0] pay,
                                                   logic [DUR_W-1:0] dur);
    deque_status_t r;
    int unsigned   back;
    int unsigned   cnt;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (ring_next(ring_tail) != ring_head) begin
          seg_pay_ring[ring_tail] = pay;
          seg_dur_ring[ring_tail] = dur;
          ring_total = ring_total + SUM_W'(dur);
          ring_tail  = ring_next(ring_tail);
          r.accepted = 1'b1;
        end
      end
      OP_FETCH: begin
        if (ring_head != ring_tail) begin
          r.payload  = seg_pay_ring[ring_head];
          r.duration = seg_dur_ring[ring_head];
          ring_total = ring_total - SUM_W'(seg_dur_ring[ring_head]);
          ring_head  = ring_next(ring_head);
          r.accepted = 1'b1;
        end
      end
      OP_DROP_BACK: begin
        if (ring_head != ring_tail) begin
          ring_tail  = ring_prev(ring_tail);
          ring_total = ring_total - SUM_W'(seg_dur_ring[ring_tail]);
          r.accepted = 1'b1;
        end
      end
      OP_DROP_FRONT: begin
        if (ring_head != ring_tail) begin
          ring_total = ring_total - SUM_W'(seg_dur_ring[ring_head]);
          ring_head  = ring_next(ring_head);
          r.accepted = 1'b1;
        end
      end
      OP_CLEAR: begin
        ring_head  = 0;
        ring_tail  = 0;
        ring_total = '0;
        r.accepted = 1'b1;
      end
      default: ;
    endcase
    cnt        = (ring_tail + DEPTH - ring_head) % DEPTH;
    back       = ring_prev(ring_tail);
    r.is_empty = (ring_head == ring_tail);
    r.is_full  = (ring_next(ring_tail) == ring_head);
    r.count    = CNT_W'(cnt);
    r.total    = ring_total;
    if (!r.is_empty) begin
      r.front_payload  = seg_pay_ring[ring_head];
      r.front_duration = seg_dur_ring[ring_head];
      r.back_payload   = seg_pay_ring[back];
      r.back_duration  = seg_dur_ring[back];
    end
    if (!r.accepted) ops_rejected++;
    if (r.is_full) full_hits++;
    if (cnt > peak_count) peak_count = cnt;
    return r;
  endfunction

  function automatic logic [PAY_W-1:0] rand_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [DUR_W-1:0] rand_duration();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // drives one operation beat at the falling edge and waits for the block to take it
  task automatic send_beat(logic [OP_W-1:0] op, logic [PAY_W-1:0] pay, logic [DUR_W-1:0] dur);
    int unsigned gap;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) < 22) gap = $urandom_range(1, 6);
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start               <= 1'b1;
    in_operation        <= op;
    in_segment_payload  <= pay;
    in_segment_duration <= dur;
    do @(posedge clk); while (!(start && !busy));
    status_q.push_back(apply_deque_op(op, pay, dur));
    beats_sent++;
  endtask

  task automatic test_empty_queue();
    send_beat(OP_FETCH, '1, '1);
    send_beat(OP_DROP_BACK, '0, '0);
    send_beat(OP_DROP_FRONT, '1, '1);
    for (int op = OP_FIRST_RSVD; op <= OP_LAST_RSVD; op++)
      send_beat(OP_W'(op), rand_payload(), rand_duration());
    send_beat(OP_CLEAR, '0, '0);
  endtask

  task automatic test_field_extremes();
    send_beat(OP_PUSH, '1, '1);
    send_beat(OP_PUSH, '0, '0);
    send_beat(OP_PUSH, {16{4'hA}}, {8{4'h5}});
    send_beat(OP_PUSH, {16{4'h5}}, {8{4'hA}});
    send_beat(OP_FETCH, '0, '0);
    send_beat(OP_DROP_BACK, '0, '0);
    send_beat(OP_LAST_RSVD, '1, '1);
    send_beat(OP_DROP_FRONT, '0, '0);
    send_beat(OP_PUSH, 64'd1, 32'd1);
    send_beat(OP_CLEAR, '1, '1);
    send_beat(OP_FETCH, '0, '0);
  endtask

  // fill to capacity, bounce off the full state, then drain past empty
  task automatic test_fill_and_drain();
    send_beat(OP_CLEAR, '0, '0);
    repeat (DEPTH - 1) send_beat(OP_PUSH, rand_payload(), rand_duration());
    send_beat(OP_PUSH, '1, '1);
    send_beat(OP_FIRST_RSVD, '0, '0);
    send_beat(OP_DROP_BACK, '0, '0);
    send_beat(OP_PUSH, '1, '1);
    send_beat(OP_PUSH, '0, '0);
    repeat (DEPTH) send_beat(OP_FETCH, '0, '0);
  endtask

  // runs of fill-heavy, drain-heavy or balanced traffic with some clears and junk codes
  task automatic test_random_traffic(int unsigned n_ops);
    int unsigned done_ops;
    int unsigned push_pct;
    int unsigned run_len;
    int unsigned roll;
    logic [OP_W-1:0] op;
    done_ops = 0;
    while (done_ops < n_ops) begin
      case ($urandom_range(0, 2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      run_len = $urandom_range(8, 80);
      no_gaps = (done_ops >= n_ops / 3) && (done_ops < n_ops / 2);
      repeat (run_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          send_beat(OP_W'($urandom_range(OP_FIRST_RSVD, OP_LAST_RSVD)), rand_payload(),
                    rand_duration());
        end else begin
          if (roll < 5) begin
            op = OP_CLEAR;
          end else if ($urandom_range(0, 99) < push_pct) begin
            op = OP_PUSH;
          end else begin
            case ($urandom_range(0, 2))
              0:       op = OP_FETCH;
              1:       op = OP_DROP_BACK;
              default: op = OP_DROP_FRONT;
            endcase
          end
          send_beat(op, rand_payload(), rand_duration());
          done_ops++;
        end
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic check_field(int unsigned idx, string fname, logic [63:0] want,
                             logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("result %0d: %s expected 0x%0h, got 0x%0h", idx, fname, want, got);
    end
  endtask

  // result beats are taken in the cycle they show; compare with the oldest prediction
  always @(posedge clk) begin
    deque_status_t exp_s;
    if (rst_n && out_valid) begin
      if (status_q.size() == 0) begin
        unexpected_count++;
        if (unexpected_count <= MAX_REPORTS)
          $display("unexpected result beat with nothing pending");
      end else begin
        exp_s = status_q.pop_front();
        check_field(results_checked, "accepted", exp_s.accepted, out_accepted);
        check_field(results_checked, "payload", exp_s.payload, out_payload);
        check_field(results_checked, "duration", exp_s.duration, out_duration);
        check_field(results_checked, "is_empty", exp_s.is_empty, out_is_empty);
        check_field(results_checked, "is_full", exp_s.is_full, out_is_full);
        check_field(results_checked, "item_count", exp_s.count, out_item_count);
        check_field(results_checked, "total_duration", exp_s.total, out_total_duration);
        check_field(results_checked, "front_payload", exp_s.front_payload, out_front_payload);
        check_field(results_checked, "front_duration", exp_s.front_duration,
                    out_front_duration);
        check_field(results_checked, "back_payload", exp_s.back_payload, out_back_payload);
        check_field(results_checked, "back_duration", exp_s.back_duration, out_back_duration);
        results_checked++;
      end
    end
  end

  // stall detector: cycles with neither an input nor a result beat
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("segment_deque_with_duration_sum test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n               = 1'b0;
    start               = 1'b0;
    in_operation        = OP_PUSH;
    in_segment_payload  = '0;
    in_segment_duration = '0;
    ring_head           = 0;
    ring_tail           = 0;
    ring_total          = '0;
    no_gaps             = 1'b0;
    beats_sent          = 0;
    ops_rejected        = 0;
    peak_count          = 0;
    full_hits           = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_field_extremes();
    test_fill_and_drain();
    test_random_traffic(RANDOM_OPS);

    @(negedge clk);
    start <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d operation beats sent, %0d results checked, %0d rejected operations",
             beats_sent, results_checked, ops_rejected);
    $display("peak occupancy %0d of %0d, full state seen %0d times, %0d field mismatches",
             peak_count, DEPTH - 1, full_hits, mismatch_count);
    if (mismatch_count == 0 && unexpected_count == 0 && status_q.size() == 0) begin
      $display("segment_deque_with_duration_sum test passed");
    end else begin
      $display("segment_deque_with_duration_sum test failed");
    end
    $finish;
  end

endmodule
